// ===== src/token_bucket_packet_shaper_assert.svh =====
// Assertion macros used by the token bucket packet shaper top level.
`ifndef TOKEN_BUCKET_PACKET_SHAPER_ASSERT_SVH
`define TOKEN_BUCKET_PACKET_SHAPER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define TBPS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define TBPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tbps_pkg.sv =====
// Package with the shared types and constants of the token bucket packet shaper.
package tbps_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int TOKEN_BITS  = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W       = (TOKEN_BITS > 16) ? TOKEN_BITS : 16;

  typedef logic [TOKEN_BITS-1:0] tok_t;
  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [CMP_W-1:0]      cmp_t;

  localparam ptr_t PTR_LAST = ptr_t'(QUEUE_DEPTH - 1);
  localparam cnt_t CNT_FULL = cnt_t'(QUEUE_DEPTH);
  localparam tok_t TOK_MAX  = {TOKEN_BITS{1'b1}};
  localparam logic [15:0] DEPTH_RESET = 16'd10;

  typedef enum logic [2:0] {
    RES_TOKEN_KEPT  = 3'd0,
    RES_TOKEN_DROP  = 3'd1,
    RES_TOO_BIG     = 3'd2,
    RES_QUEUE_FULL  = 3'd3,
    RES_QUEUED      = 3'd4,
    RES_RELEASED    = 3'd5
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_REL
  } state_t;

  typedef struct packed {
    logic [15:0] need;
    logic [15:0] id;
  } entry_t;

  typedef struct packed {
    logic   rd_en;
    ptr_t   rd_addr;
    logic   wr_en;
    ptr_t   wr_addr;
    entry_t wr_data;
  } ram_req_t;

endpackage

// ===== src/tbps_queue_ram.sv =====
// Wait queue storage: one write port and one registered read port.
module tbps_queue_ram (
  input  logic               clk,
  input  tbps_pkg::ram_req_t req,
  output tbps_pkg::entry_t   rd_data
);

  tbps_pkg::entry_t mem [tbps_pkg::QUEUE_DEPTH];
  tbps_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/tbps_ctrl.sv =====
// Sequencer of the shaper: token count, queue pointers and the result beats.
module tbps_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_action,
  input  logic [15:0]        in_tokens_needed,
  input  logic [15:0]        in_packet_id,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_bucket_depth,
  output logic               out_strobe,
  output logic [2:0]         out_event_res,
  output logic [15:0]        out_event_packet_id,
  output logic [15:0]        out_tokens_after,
  output logic [6:0]         out_queue_fill,
  output logic               out_last,
  output tbps_pkg::ram_req_t ram_req,
  input  tbps_pkg::entry_t   ram_rd_data
);

  tbps_pkg::state_t state_r, state_nxt;

  logic             act_r;
  logic [15:0]      need_r;
  logic [15:0]      id_r;
  logic [15:0]      depth_r;
  tbps_pkg::tok_t   tok_r, tok_nxt;
  tbps_pkg::ptr_t   head_r, head_nxt;
  tbps_pkg::ptr_t   tail_r, tail_nxt;
  tbps_pkg::cnt_t   cnt_r, cnt_nxt;
  logic [15:0]      rel_need_r, rel_need_nxt;
  logic [15:0]      rel_id_r, rel_id_nxt;

  logic             accept;
  logic             too_big;
  logic             full;
  logic             queued;
  logic             keep;
  logic             can_rel;
  tbps_pkg::tok_t   tok_eval;
  tbps_pkg::cnt_t   cnt_eval;
  tbps_pkg::entry_t head_entry;
  tbps_pkg::res_t   first_res;

  assign accept    = start && (state_r == tbps_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // Evaluation of the latched item against the current state.
  always_comb begin
    too_big  = act_r && (need_r > depth_r);
    full     = act_r && (cnt_r == tbps_pkg::CNT_FULL);
    queued   = act_r && !too_big && !full;
    keep     = (tbps_pkg::cmp_t'(tok_r) < tbps_pkg::cmp_t'(depth_r)) &&
               (tok_r != tbps_pkg::TOK_MAX);
    tok_eval = (!act_r && keep) ? tok_r + tbps_pkg::tok_t'(1) : tok_r;
    cnt_eval = queued ? cnt_r + tbps_pkg::cnt_t'(1) : cnt_r;
    // An empty queue has no stored head yet: the new packet becomes the head.
    if (queued && (cnt_r == '0)) begin
      head_entry = '{need: need_r, id: id_r};
    end else begin
      head_entry = ram_rd_data;
    end
    can_rel = !too_big && !full && (cnt_eval != '0) &&
              (tbps_pkg::cmp_t'(tok_eval) >= tbps_pkg::cmp_t'(head_entry.need));
    if (!act_r) begin
      first_res = keep ? tbps_pkg::RES_TOKEN_KEPT : tbps_pkg::RES_TOKEN_DROP;
    end else if (too_big) begin
      first_res = tbps_pkg::RES_TOO_BIG;
    end else if (full) begin
      first_res = tbps_pkg::RES_QUEUE_FULL;
    end else begin
      first_res = tbps_pkg::RES_QUEUED;
    end
  end

  // Datapath next values.
  always_comb begin
    tok_nxt      = tok_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    cnt_nxt      = cnt_r;
    rel_need_nxt = rel_need_r;
    rel_id_nxt   = rel_id_r;
    ram_req      = '0;
    ram_req.rd_addr = head_r;
    ram_req.wr_addr = tail_r;
    ram_req.wr_data = '{need: need_r, id: id_r};
    unique case (state_r)
      tbps_pkg::ST_IDLE: begin
        ram_req.rd_en = accept;
      end
      tbps_pkg::ST_EVAL: begin
        tok_nxt       = tok_eval;
        cnt_nxt       = cnt_eval;
        ram_req.wr_en = queued;
        if (queued) begin
          tail_nxt = (tail_r == tbps_pkg::PTR_LAST) ? '0 : tail_r + tbps_pkg::ptr_t'(1);
        end
        rel_need_nxt = head_entry.need;
        rel_id_nxt   = head_entry.id;
      end
      tbps_pkg::ST_REL: begin
        tok_nxt  = tok_r - tbps_pkg::tok_t'(rel_need_r);
        cnt_nxt  = cnt_r - tbps_pkg::cnt_t'(1);
        head_nxt = (head_r == tbps_pkg::PTR_LAST) ? '0 : head_r + tbps_pkg::ptr_t'(1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tbps_pkg::ST_IDLE: if (start) state_nxt = tbps_pkg::ST_EVAL;
      tbps_pkg::ST_EVAL: state_nxt = can_rel ? tbps_pkg::ST_REL : tbps_pkg::ST_IDLE;
      tbps_pkg::ST_REL:  state_nxt = tbps_pkg::ST_IDLE;
      default:           state_nxt = tbps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy                = (state_r != tbps_pkg::ST_IDLE);
    out_strobe          = 1'b0;
    out_event_res       = tbps_pkg::RES_TOKEN_KEPT;
    out_event_packet_id = '0;
    out_tokens_after    = 16'(tok_r);
    out_queue_fill      = 7'(cnt_r);
    out_last            = 1'b1;
    unique case (state_r)
      tbps_pkg::ST_IDLE: begin
      end
      tbps_pkg::ST_EVAL: begin
        out_strobe          = 1'b1;
        out_event_res       = first_res;
        out_event_packet_id = act_r ? id_r : 16'd0;
        out_tokens_after    = 16'(tok_eval);
        out_queue_fill      = 7'(cnt_eval);
        out_last            = !can_rel;
      end
      tbps_pkg::ST_REL: begin
        out_strobe          = 1'b1;
        out_event_res       = tbps_pkg::RES_RELEASED;
        out_event_packet_id = rel_id_r;
        out_tokens_after    = 16'(tok_nxt);
        out_queue_fill      = 7'(cnt_nxt);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tbps_pkg::ST_IDLE;
      depth_r <= tbps_pkg::DEPTH_RESET;
      tok_r   <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      tok_r   <= tok_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        depth_r <= cfg_bucket_depth;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= in_action;
      need_r <= in_tokens_needed;
      id_r   <= in_packet_id;
    end
    rel_need_r <= rel_need_nxt;
    rel_id_r   <= rel_id_nxt;
  end

endmodule

// ===== src/token_bucket_packet_shaper.sv =====
// Token bucket packet shaper: top level.
//
// Usage: an item (a token tick or a packet with id and token need) is taken
// at a clock edge with start high and busy low. busy stays high until all of
// its results have been shown. Each result beat is on the out_ ports for one
// cycle with out_strobe high; out_last marks the final beat of an item.
// The receiver cannot stall: every strobed beat is taken as it appears.
// Timing: the head of the wait queue is read from the queue memory at the
// accept edge; the first result appears in the next cycle. If the head packet
// is released, a second beat follows in the next cycle. An item thus goes
// through ST_EVAL, and through ST_REL as well when it releases a packet.
// bucket_depth is written through cfg_valid/cfg_ready (always ready); the
// user must write it only while the block is idle, a rule the block itself
// leaves unchecked. Reset (rst_n low, synchronous) empties the queue, clears
// the token count and sets bucket_depth to 10; the queue memory needs no
// clearing, since only entries written since reset are ever read.
`include "token_bucket_packet_shaper_assert.svh"

module token_bucket_packet_shaper (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [15:0] in_tokens_needed,
  input  logic [15:0] in_packet_id,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_bucket_depth,
  output logic        out_strobe,
  output logic [2:0]  out_event_res,
  output logic [15:0] out_event_packet_id,
  output logic [15:0] out_tokens_after,
  output logic [6:0]  out_queue_fill,
  output logic        out_last
);

  tbps_pkg::ram_req_t ram_req;
  tbps_pkg::entry_t   ram_rd_data;

  tbps_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_action           (in_action),
    .in_tokens_needed    (in_tokens_needed),
    .in_packet_id        (in_packet_id),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_bucket_depth    (cfg_bucket_depth),
    .out_strobe          (out_strobe),
    .out_event_res       (out_event_res),
    .out_event_packet_id (out_event_packet_id),
    .out_tokens_after    (out_tokens_after),
    .out_queue_fill      (out_queue_fill),
    .out_last            (out_last),
    .ram_req             (ram_req),
    .ram_rd_data         (ram_rd_data)
  );

  tbps_queue_ram u_queue_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

  `TBPS_ASSERT_NEXT(a_accept_busy, start && !busy, busy && out_strobe, "accepted item gave no beat")
  `TBPS_ASSERT_NEXT(a_release_follows, out_strobe && !out_last, out_strobe && out_last && (out_event_res == tbps_pkg::RES_RELEASED), "missing release beat")
  `TBPS_ASSERT_IMPLY(a_strobe_busy, out_strobe, busy, "result beat while idle")
  `TBPS_ASSERT_IMPLY(a_release_second, out_strobe && (out_event_res == tbps_pkg::RES_RELEASED), $past(out_strobe) && !$past(out_last), "release beat without first beat")

endmodule

// ===== tb/token_bucket_packet_shaper_test.sv =====
// Testbench for the token bucket packet shaper: directed table, random phases, event predictor.
module token_bucket_packet_shaper_test;
  import tbps_pkg::*;

  localparam logic ACT_TICK   = 1'b0;
  localparam logic ACT_PACKET = 1'b1;
  localparam int PLAN_LEN     = 18;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 60;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PRINT_CAP    = 30;

  typedef struct packed {
    res_t        res;
    logic [15:0] pid;
    tok_t        tok;
    cnt_t        fill;
    logic        last;
  } shaper_event_t;

  // One row of the directed plan. Rows with known set carry the event typed in.
  typedef struct packed {
    logic        set_depth;
    logic [15:0] depth;
    logic        action;
    logic [15:0] need;
    logic [15:0] pid;
    logic [16:0] reps;
    logic        known;
    res_t        res;
    tok_t        tok;
    cnt_t        fill;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_action = ACT_TICK;
  logic [15:0] in_tokens_needed = '0;
  logic [15:0] in_packet_id = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_bucket_depth = '0;
  logic        out_strobe;
  logic [2:0]  out_event_res;
  logic [15:0] out_event_packet_id;
  logic [15:0] out_tokens_after;
  logic [6:0]  out_queue_fill;
  logic        out_last;

  // Predictor state: bucket, depth register and the wait queue.
  tok_t          bucket_tokens = '0;
  logic [15:0]   depth_setting = DEPTH_RESET;
  entry_t        fifo_mem [QUEUE_DEPTH];
  ptr_t          fifo_head = '0;
  ptr_t          fifo_tail = '0;
  cnt_t          fifo_fill = '0;
  shaper_event_t next_ev [2];

  shaper_event_t pending_events [$];
  int            err_count = 0;
  int            cycle_count = 0;
  plan_row_t     plan [PLAN_LEN];

  token_bucket_packet_shaper u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_action           (in_action),
    .in_tokens_needed    (in_tokens_needed),
    .in_packet_id        (in_packet_id),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_bucket_depth    (cfg_bucket_depth),
    .out_strobe          (out_strobe),
    .out_event_res       (out_event_res),
    .out_event_packet_id (out_event_packet_id),
    .out_tokens_after    (out_tokens_after),
    .out_queue_fill      (out_queue_fill),
    .out_last            (out_last)
  );

  always #10 clk = ~clk;

  task automatic note_mismatch(input string what);
    err_count++;
    if (err_count <= PRINT_CAP) $display("mismatch: %s", what);
  endtask

  // Works out the events one item causes and updates the predictor state.
  function automatic int shape_item(input logic act, input logic [15:0] need,
                                    input logic [15:0] pid);
    entry_t      head_e;
    res_t        first_res;
    logic [15:0] first_id;
    first_id = '0;
    if (act == ACT_TICK) begin
      if (bucket_tokens < depth_setting && bucket_tokens != TOK_MAX) begin
        bucket_tokens = bucket_tokens + 1'b1;
        first_res = RES_TOKEN_KEPT;
      end else begin
        first_res = RES_TOKEN_DROP;
      end
    end else begin
      // Rejected packets give one event and never trigger a release.
      if (need > depth_setting) begin
        next_ev[0] = '{RES_TOO_BIG, pid, bucket_tokens, fifo_fill, 1'b1};
        return 1;
      end
      if (fifo_fill == CNT_FULL) begin
        next_ev[0] = '{RES_QUEUE_FULL, pid, bucket_tokens, fifo_fill, 1'b1};
        return 1;
      end
      fifo_mem[fifo_tail] = '{need, pid};
      fifo_tail = (fifo_tail == PTR_LAST) ? '0 : ptr_t'(fifo_tail + 1'b1);
      fifo_fill = fifo_fill + 1'b1;
      first_res = RES_QUEUED;
      first_id = pid;
    end
    next_ev[0] = '{first_res, first_id, bucket_tokens, fifo_fill, 1'b1};
    if (fifo_fill == '0) return 1;
    head_e = fifo_mem[fifo_head];
    if (bucket_tokens < head_e.need) return 1;
    bucket_tokens = bucket_tokens - head_e.need;
    fifo_head = (fifo_head == PTR_LAST) ? '0 : ptr_t'(fifo_head + 1'b1);
    fifo_fill = fifo_fill - 1'b1;
    next_ev[0].last = 1'b0;
    next_ev[1] = '{RES_RELEASED, head_e.id, bucket_tokens, fifo_fill, 1'b1};
    return 2;
  endfunction

  // Drives one item and returns at the edge that accepts it.
  task automatic send_item(input logic act, input logic [15:0] need, input logic [15:0] pid,
                           input logic use_typed, input shaper_event_t typed_ev);
    int n;
    in_action <= act;
    in_tokens_needed <= need;
    in_packet_id <= pid;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    n = shape_item(act, need, pid);
    if (use_typed) begin
      pending_events.push_back(typed_ev);
    end else begin
      for (int i = 0; i < n; i++) pending_events.push_back(next_ev[i]);
    end
  endtask

  // Stops sending and waits until every expected beat has come.
  task automatic drain;
    start <= 1'b0;
    while (pending_events.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_depth(input logic [15:0] value);
    cfg_bucket_depth <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    depth_setting = value;
  endtask

  always @(posedge clk) begin : check_beat
    shaper_event_t want;
    if (rst_n && out_strobe) begin
      if (pending_events.size() == 0) begin
        note_mismatch($sformatf("beat with nothing expected: res %0d id %h",
                                out_event_res, out_event_packet_id));
      end else begin
        want = pending_events.pop_front();
        if (out_event_res !== want.res)
          note_mismatch($sformatf("event_res %0d, want %0d", out_event_res, want.res));
        if (out_event_packet_id !== want.pid)
          note_mismatch($sformatf("event_packet_id %h, want %h",
                                  out_event_packet_id, want.pid));
        if (out_tokens_after !== want.tok)
          note_mismatch($sformatf("tokens_after %0d, want %0d", out_tokens_after, want.tok));
        if (out_queue_fill !== want.fill)
          note_mismatch($sformatf("queue_fill %0d, want %0d", out_queue_fill, want.fill));
        if (out_last !== want.last)
          note_mismatch($sformatf("last %0d, want %0d", out_last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("token_bucket_packet_shaper test failed");
      $finish;
    end
  end

  initial begin
    shaper_event_t typed_ev;
    logic        act;
    logic [15:0] need;
    int          sel;
    int          tick_pct;
    int          burst;
    int          gap;
    int          sent;

    plan = '{
      // Fresh after reset: depth 10, empty bucket.
      '{1'b0, 16'd0,      ACT_TICK,   16'd0,      16'h0000, 17'd1,     1'b1, RES_TOKEN_KEPT,
        16'd1,  7'd0},
      '{1'b0, 16'd0,      ACT_PACKET, 16'd11,     16'hFFFF, 17'd1,     1'b1, RES_TOO_BIG,
        16'd1,  7'd0},
      // Zero need goes straight through.
      '{1'b0, 16'd0,      ACT_PACKET, 16'd0,      16'h0000, 17'd1,     1'b0, RES_TOKEN_KEPT,
        16'd0,  7'd0},
      '{1'b0, 16'd0,      ACT_PACKET, 16'd3,      16'h1234, 17'd1,     1'b0, RES_TOKEN_KEPT,
        16'd0,  7'd0},
      '{1'b0, 16'd0,      ACT_TICK,   16'd0,      16'h0000, 17'd2,     1'b0, RES_TOKEN_KEPT,
        16'd0,  7'd0},
      '{1'b0, 16'd0,      ACT_TICK,   16'd0,      16'h0000, 17'd9,     1'b0, RES_TOKEN_KEPT,
        16'd0,  7'd0},
      '{1'b0, 16'd0,      ACT_TICK,   16'd0,      16'h0000, 17'd1,     1'b1, RES_TOKEN_KEPT,
        16'd10, 7'd0},
      '{1'b0, 16'd0,      ACT_TICK,   16'd0,      16'h0000, 17'd1,     1'b1, RES_TOKEN_DROP,
        16'd10, 7'd0},
      // Depth lowered under the count: the count stays, ticks drop.
      '{1'b1, 16'd5,      ACT_TICK,   16'd0,      16'h0000, 17'd1,     1'b1, RES_TOKEN_DROP,
        16'd10, 7'd0},
      '{1'b0, 16'd0,      ACT_PACKET, 16'd6,      16'hAAAA, 17'd1,     1'b1, RES_TOO_BIG,
        16'd10, 7'd0},
      '{1'b0, 16'd0,      ACT_PACKET, 16'd5,      16'h5555, 17'd1,     1'b0, RES_TOKEN_KEPT,
        16'd0,  7'd0},
      '{1'b1, 16'd0,      ACT_PACKET, 16'd0,      16'h0001, 17'd1,     1'b0, RES_TOKEN_KEPT,
        16'd0,  7'd0},
      '{1'b0, 16'd0,      ACT_TICK,   16'd0,      16'h0000, 17'd1,     1'b1, RES_TOKEN_DROP,
        16'd5,  7'd0},
      '{1'b0, 16'd0,      ACT_PACKET, 16'd1,      16'h0002, 17'd1,     1'b1, RES_TOO_BIG,
        16'd5,  7'd0},
      // Widest depth: one packet takes every token in the bucket.
      '{1'b1, 16'hFFFF,   ACT_PACKET, 16'd5,      16'h8000, 17'd1,     1'b0, RES_TOKEN_KEPT,
        16'd0,  7'd0},
      // Starved bucket: the queue fills, then turns packets away.
      '{1'b0, 16'd0,      ACT_PACKET, 16'd1,      16'h0100, 17'd64,    1'b0, RES_TOKEN_KEPT,
        16'd0,  7'd0},
      '{1'b0, 16'd0,      ACT_PACKET, 16'd0,      16'h7FFF, 17'd1,     1'b1, RES_QUEUE_FULL,
        16'd0,  CNT_FULL},
      '{1'b0, 16'd0,      ACT_TICK,   16'd0,      16'h0000, 17'd64,    1'b0, RES_TOKEN_KEPT,
        16'd0,  7'd0}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[r]) begin
      if (plan[r].set_depth) begin
        drain();
        write_depth(plan[r].depth);
      end
      typed_ev = '{plan[r].res, (plan[r].action == ACT_PACKET) ? plan[r].pid : 16'h0000,
                   plan[r].tok, plan[r].fill, 1'b1};
      for (int k = 0; k < int'(plan[r].reps); k++)
        send_item(plan[r].action, plan[r].need, plan[r].pid + 16'(k), plan[r].known, typed_ev);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: write_depth(16'($urandom_range(16, 1)));
        1: write_depth(16'd0);
        2: write_depth(16'($urandom_range(8, 2)));
        3: write_depth(16'hFFFF);
        4: write_depth(16'($urandom));
        default: write_depth(16'($urandom_range(64, 17)));
      endcase
      tick_pct = $urandom_range(80, 20);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(24, 1);
        for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
          act = ($urandom_range(99, 0) < tick_pct) ? ACT_TICK : ACT_PACKET;
          sel = $urandom_range(9, 0);
          // Mostly needs the bucket can cover, some too big, some anything.
          if (sel < 5)
            need = 16'($urandom_range(depth_setting, 0));
          else if (sel < 8)
            need = 16'($urandom_range((depth_setting < 6) ? depth_setting : 6, 0));
          else if (sel == 8 && depth_setting != 16'hFFFF)
            need = 16'($urandom_range(65535, depth_setting + 1));
          else
            need = 16'($urandom);
          send_item(act, need, 16'($urandom), 1'b0, typed_ev);
          sent++;
        end
        if ($urandom_range(29, 0) == 0) begin
          drain();
        end else begin
          gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
          if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (pending_events.size() != 0)
      note_mismatch($sformatf("%0d expected beats never came", pending_events.size()));
    if (err_count == 0)
      $display("token_bucket_packet_shaper test passed");
    else
      $display("token_bucket_packet_shaper test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/tbps_pkg.sv
src/tbps_queue_ram.sv
src/tbps_ctrl.sv
src/token_bucket_packet_shaper.sv
tb/token_bucket_packet_shaper_test.sv
